FILE: sv/nfpa_pkg.sv
// ----------------------------------------------------------------------------
// Next-fit page run allocator: shared package
// Widths, codes, command structs and byte helpers used by every file of
// the allocator.
// ----------------------------------------------------------------------------
package nfpa_pkg;

   // Region geometry.
   localparam int MAX_PAGES  = 32;
   localparam int PAGE_BYTES = 65536;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

   // Field widths.
   localparam int PAGE_IDX_W = 5;
   localparam int PAGE_CNT_W = 6;
   localparam int BYTES_W    = 22;
   localparam int WANT_W     = BYTES_W - PAGE_SHIFT + 1;
   localparam int REQ_TYPE_W = 2;
   localparam int STATUS_W   = 2;

   // Register reset value.
   localparam logic [PAGE_CNT_W-1:0] TOTAL_PAGES_RESET = PAGE_CNT_W'(MAX_PAGES);

   // Request codes.
   typedef enum logic [REQ_TYPE_W-1:0] {
      RQ_ALLOC = 2'd0,
      RQ_FREE  = 2'd1,
      RQ_STATS = 2'd2
   } req_code_type;

   // Status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_NOSPACE = 2'd2
   } status_code_type;

   // Bitmap operations.
   typedef enum logic [1:0] {
      BM_NONE  = 2'd0,
      BM_SET   = 2'd1,
      BM_CLEAR = 2'd2
   } bm_op_type;

   // Command from the sequencer to the bitmap unit.
   typedef struct packed {
      bm_op_type              op;
      logic [PAGE_IDX_W-1:0]  start;
      logic [PAGE_CNT_W-1:0]  len;
   } bm_cmd_type;

   // Answers of the bitmap unit for the current command operands.
   typedef struct packed {
      logic range_free;
      logic bit_used;
   } bm_stat_type;

   // One request beat.
   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      logic [BYTES_W-1:0]    alloc_bytes;
      logic [PAGE_IDX_W-1:0] free_first_page;
      logic [PAGE_CNT_W-1:0] free_page_count;
   } req_item_type;

   // One response beat.
   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [PAGE_IDX_W-1:0] run_first;
      logic [PAGE_CNT_W-1:0] run_len;
      logic [BYTES_W-1:0]    total_bytes;
      logic [BYTES_W-1:0]    avail_bytes;
      logic [BYTES_W-1:0]    largest_free_bytes;
   } rsp_item_type;

   // Byte size of a page count.
   function automatic logic [BYTES_W-1:0] pages_to_bytes(input logic [PAGE_CNT_W-1:0] pages);
      return BYTES_W'(pages) << PAGE_SHIFT;
   endfunction

   // Byte size rounded up to whole pages.
   function automatic logic [WANT_W-1:0] bytes_to_pages(input logic [BYTES_W-1:0] nbytes);
      logic [BYTES_W:0] sum;
      sum = {1'b0, nbytes} + (BYTES_W+1)'(PAGE_BYTES - 1);
      return WANT_W'(sum >> PAGE_SHIFT);
   endfunction

endpackage

FILE: sv/nfpa_if.sv
// ----------------------------------------------------------------------------
// Next-fit page run allocator: channel interfaces
// Valid/ready channels for request beats and response beats.
// ----------------------------------------------------------------------------
interface nfpa_req_if;
   logic                           valid;
   logic                           ready;
   logic [nfpa_pkg::REQ_TYPE_W-1:0] req_type;
   logic [nfpa_pkg::BYTES_W-1:0]    alloc_bytes;
   logic [nfpa_pkg::PAGE_IDX_W-1:0] free_first_page;
   logic [nfpa_pkg::PAGE_CNT_W-1:0] free_page_count;

   modport source (output valid, req_type, alloc_bytes, free_first_page, free_page_count,
                   input ready);
   modport sink (input valid, req_type, alloc_bytes, free_first_page, free_page_count,
                 output ready);
endinterface

interface nfpa_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [nfpa_pkg::STATUS_W-1:0]   status;
   logic [nfpa_pkg::PAGE_IDX_W-1:0] run_first;
   logic [nfpa_pkg::PAGE_CNT_W-1:0] run_len;
   logic [nfpa_pkg::BYTES_W-1:0]    total_bytes;
   logic [nfpa_pkg::BYTES_W-1:0]    avail_bytes;
   logic [nfpa_pkg::BYTES_W-1:0]    largest_free_bytes;

   modport source (output valid, status, run_first, run_len, total_bytes, avail_bytes,
                   largest_free_bytes, input ready);
   modport sink (input valid, status, run_first, run_len, total_bytes, avail_bytes,
                 largest_free_bytes, output ready);
endinterface

FILE: sv/next_fit_page_run_allocator_core.sv
// ----------------------------------------------------------------------------
// Next-fit page run allocator core
// Allocates, releases and reports contiguous page runs of a paged region.
// ----------------------------------------------------------------------------
// One request is worked on at a time; req.ready is high only while the
// sequencer is idle, and a finished response waits in an output register so
// the next request can be taken before it is read. A free, an invalid request
// or an allocate refused at decode goes from decode straight to the response.
// An allocate that searches first wraps the search pointer by repeated
// subtraction when it is at or past the region size after the register was
// lowered, then tries candidate starts (at most the region size of them) and
// reports no space when no run fits. A statistics request reads each page of
// the region, or none when the region size is zero or above MAX_PAGES. The
// single run-mask unit over the used-page bitmap checks one candidate run or
// reads one page per cycle.
module next_fit_page_run_allocator_core (
   input  logic                            clock,
   input  logic                            reset,
   nfpa_req_if.sink                        req,
   nfpa_rsp_if.source                      rsp,
   input  logic                            csr_wr_en,
   input  logic [nfpa_pkg::PAGE_CNT_W-1:0] csr_wr_data
);
   import nfpa_pkg::*;

   logic [PAGE_CNT_W-1:0] region_size_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_item_type          rsp_ff;
   req_item_type          req_item;
   bm_cmd_type            bm_cmd;
   bm_stat_type           bm_stat;
   rsp_item_type          seq_res;
   logic                  seq_idle;
   logic                  seq_res_valid;
   logic                  res_take;

   // Region size register.
   always_ff @(posedge clock) begin
      if (reset) begin
         region_size_ff <= TOTAL_PAGES_RESET;
      end else if (csr_wr_en) begin
         region_size_ff <= csr_wr_data;
      end
   end

   // Request beat.
   always_comb begin
      req_item.req_type        = req.req_type;
      req_item.alloc_bytes     = req.alloc_bytes;
      req_item.free_first_page = req.free_first_page;
      req_item.free_page_count = req.free_page_count;
      req.ready                = seq_idle;
   end

   nfpa_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (req.valid && seq_idle),
      .item        (req_item),
      .region_size (region_size_ff),
      .idle        (seq_idle),
      .cmd         (bm_cmd),
      .stat        (bm_stat),
      .res_valid   (seq_res_valid),
      .res         (seq_res),
      .res_take    (res_take)
   );

   nfpa_bitmap u_bitmap (
      .clock (clock),
      .reset (reset),
      .cmd   (bm_cmd),
      .stat  (bm_stat)
   );

   // Response register: loads when empty or being drained.
   always_comb begin
      res_take     = seq_res_valid && (!rsp_valid_ff || rsp.ready);
      rsp_valid_in = res_take || (rsp_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_ff <= seq_res;
      end
   end

   always_comb begin
      rsp.valid              = rsp_valid_ff;
      rsp.status             = rsp_ff.status;
      rsp.run_first          = rsp_ff.run_first;
      rsp.run_len            = rsp_ff.run_len;
      rsp.total_bytes        = rsp_ff.total_bytes;
      rsp.avail_bytes        = rsp_ff.avail_bytes;
      rsp.largest_free_bytes = rsp_ff.largest_free_bytes;
   end

endmodule

FILE: sv/nfpa_bitmap.sv
// ----------------------------------------------------------------------------
// Next-fit page run allocator: used-page bitmap
// Holds one used bit per page and the shared run-mask unit that checks,
// marks and releases a run of pages, plus a single-bit read for scans.
// ----------------------------------------------------------------------------
module nfpa_bitmap (
   input  logic                 clock,
   input  logic                 reset,
   input  nfpa_pkg::bm_cmd_type cmd,
   output nfpa_pkg::bm_stat_type stat
);
   import nfpa_pkg::*;

   logic [MAX_PAGES-1:0] used_ff;
   logic [MAX_PAGES-1:0] used_in;
   logic [MAX_PAGES:0]   len_mask;
   logic [MAX_PAGES-1:0] run_mask;

   // Run mask: len ones starting at page start.
   always_comb begin
      len_mask = ((MAX_PAGES+1)'(1) << cmd.len) - (MAX_PAGES+1)'(1);
      run_mask = MAX_PAGES'(len_mask) << cmd.start;
   end

   // Status toward the sequencer.
   always_comb begin
      stat.range_free = ((used_ff & run_mask) == '0);
      stat.bit_used   = used_ff[cmd.start];
   end

   // Mark or release the run.
   always_comb begin
      used_in = used_ff;
      unique case (cmd.op)
         BM_SET:   used_in = used_ff | run_mask;
         BM_CLEAR: used_in = used_ff & ~run_mask;
         default:  used_in = used_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

endmodule

FILE: sv/nfpa_seq.sv
// ----------------------------------------------------------------------------
// Next-fit page run allocator: request sequencer
// Decodes one request and drives the bitmap unit step by step: pointer
// wrap, next-fit candidate search and marking, run release and the statistics scan.
// ----------------------------------------------------------------------------
module nfpa_seq (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  nfpa_pkg::req_item_type            item,
   input  logic [nfpa_pkg::PAGE_CNT_W-1:0]   region_size,
   output logic                              idle,
   output nfpa_pkg::bm_cmd_type              cmd,
   input  nfpa_pkg::bm_stat_type             stat,
   output logic                              res_valid,
   output nfpa_pkg::rsp_item_type            res,
   input  logic                              res_take
);
   import nfpa_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DECODE = 6'b000010,
      S_WRAP   = 6'b000100,
      S_SEARCH = 6'b001000,
      S_STATS  = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

   state_type             state_ff,   state_in;
   req_item_type          item_ff,    item_in;
   rsp_item_type          res_ff,     res_in;
   logic [WANT_W-1:0]     wanted_ff,  wanted_in;
   logic [PAGE_IDX_W-1:0] cand_ff,    cand_in;
   logic [PAGE_CNT_W-1:0] pass_ff,    pass_in;
   logic [PAGE_IDX_W-1:0] ptr_ff,     ptr_in;
   logic [PAGE_CNT_W-1:0] idx_ff,     idx_in;
   logic [PAGE_CNT_W-1:0] free_ff,    free_in;
   logic [PAGE_CNT_W-1:0] run_ff,     run_in;
   logic [PAGE_CNT_W-1:0] lrg_ff,     lrg_in;

   logic                  region_ok;
   logic [WANT_W-1:0]     wanted_calc;
   logic [WANT_W-1:0]     tp_w;
   logic [WANT_W-1:0]     end_sum;
   logic [WANT_W-1:0]     free_end;
   logic [PAGE_CNT_W-1:0] cand_next;
   logic [PAGE_CNT_W-1:0] run_nx;

   // Region checks and request arithmetic.
   always_comb begin
      region_ok   = (region_size != '0) && (region_size <= PAGE_CNT_W'(MAX_PAGES));
      wanted_calc = bytes_to_pages(item_ff.alloc_bytes);
      tp_w        = WANT_W'(region_size);
      end_sum     = WANT_W'(cand_ff) + wanted_ff;
      free_end    = WANT_W'(item_ff.free_first_page) + WANT_W'(item_ff.free_page_count);
      cand_next   = PAGE_CNT_W'(cand_ff) + PAGE_CNT_W'(1);
      run_nx      = run_ff + PAGE_CNT_W'(1);
   end

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      res_in    = res_ff;
      wanted_in = wanted_ff;
      cand_in   = cand_ff;
      pass_in   = pass_ff;
      ptr_in    = ptr_ff;
      idx_in    = idx_ff;
      free_in   = free_ff;
      run_in    = run_ff;
      lrg_in    = lrg_ff;
      cmd.op    = BM_NONE;
      cmd.start = cand_ff;
      cmd.len   = PAGE_CNT_W'(wanted_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               item_in  = item;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            res_in    = '0;
            wanted_in = wanted_calc;
            state_in  = S_DONE;
            unique case (item_ff.req_type)
               RQ_ALLOC: begin
                  if (item_ff.alloc_bytes == '0) begin
                     res_in.status = ST_INVALID;
                  end else if (!region_ok || wanted_calc > tp_w) begin
                     res_in.status = ST_NOSPACE;
                  end else begin
                     cand_in  = ptr_ff;
                     pass_in  = '0;
                     state_in = S_WRAP;
                  end
               end
               RQ_FREE: begin
                  if (!region_ok || free_end > tp_w) begin
                     res_in.status = ST_INVALID;
                  end else begin
                     cmd.op    = BM_CLEAR;
                     cmd.start = item_ff.free_first_page;
                     cmd.len   = item_ff.free_page_count;
                  end
               end
               RQ_STATS: begin
                  if (region_ok) begin
                     idx_in   = '0;
                     free_in  = '0;
                     run_in   = '0;
                     lrg_in   = '0;
                     state_in = S_STATS;
                  end
               end
               default: begin
                  res_in.status = ST_INVALID;
               end
            endcase
         end

         // Bring a stale pointer back inside the region by repeated subtraction.
         S_WRAP: begin
            if (PAGE_CNT_W'(cand_ff) >= region_size) begin
               cand_in = cand_ff - PAGE_IDX_W'(region_size);
            end else begin
               state_in = S_SEARCH;
            end
         end

         // One candidate start per cycle, in next-fit order.
         S_SEARCH: begin
            if (pass_ff == region_size) begin
               res_in.status = ST_NOSPACE;
               state_in      = S_DONE;
            end else if (end_sum <= tp_w && stat.range_free) begin
               cmd.op           = BM_SET;
               res_in.run_first = cand_ff;
               res_in.run_len   = PAGE_CNT_W'(wanted_ff);
               ptr_in           = (end_sum == tp_w) ? '0 : PAGE_IDX_W'(end_sum);
               state_in         = S_DONE;
            end else begin
               pass_in = pass_ff + PAGE_CNT_W'(1);
               cand_in = (cand_next == region_size) ? '0 : PAGE_IDX_W'(cand_next);
            end
         end

         // One page per cycle: free count and longest free run.
         S_STATS: begin
            cmd.start = PAGE_IDX_W'(idx_ff);
            if (!stat.bit_used) begin
               free_in = free_ff + PAGE_CNT_W'(1);
               run_in  = run_nx;
               lrg_in  = (run_nx > lrg_ff) ? run_nx : lrg_ff;
            end else begin
               run_in  = '0;
            end
            idx_in = idx_ff + PAGE_CNT_W'(1);
            if (idx_in == region_size) begin
               res_in.total_bytes        = pages_to_bytes(region_size);
               res_in.avail_bytes        = pages_to_bytes(free_in);
               res_in.largest_free_bytes = pages_to_bytes(lrg_in);
               state_in                  = S_DONE;
            end
         end

         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      idle      = (state_ff == S_IDLE);
      res_valid = (state_ff == S_DONE);
      res       = res_ff;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ptr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      res_ff    <= res_in;
      wanted_ff <= wanted_in;
      cand_ff   <= cand_in;
      pass_ff   <= pass_in;
      idx_ff    <= idx_in;
      free_ff   <= free_in;
      run_ff    <= run_in;
      lrg_ff    <= lrg_in;
   end

endmodule

FILE: sv/nfpa_checker.sv
// ----------------------------------------------------------------------------
// Next-fit page run allocator: port checker
// Watches the response port of the core and checks how its beats relate.
// ----------------------------------------------------------------------------
module nfpa_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [nfpa_pkg::STATUS_W-1:0]   rsp_status,
   input logic [nfpa_pkg::PAGE_IDX_W-1:0] rsp_run_first,
   input logic [nfpa_pkg::PAGE_CNT_W-1:0] rsp_run_len,
   input logic [nfpa_pkg::BYTES_W-1:0]    rsp_total_bytes,
   input logic [nfpa_pkg::BYTES_W-1:0]    rsp_avail_bytes,
   input logic [nfpa_pkg::BYTES_W-1:0]    rsp_largest_free_bytes
);
   import nfpa_pkg::*;

   // No response beat is offered right after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response beat keeps its status, run and free byte count.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_run_first) && $stable(rsp_run_len) && $stable(rsp_avail_bytes))
      else $error("stalled response changed");

   // A failed request reports no run and no total or free byte count.
   a_fail_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_run_first == '0 &&
      rsp_run_len == '0 && rsp_total_bytes == '0 && rsp_avail_bytes == '0)
      else $error("failed request carries data");

   // An allocated run ends within MAX_PAGES pages and carries no total byte count.
   a_run_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_len != '0 |->
      (WANT_W'(rsp_run_first) + WANT_W'(rsp_run_len) <= WANT_W'(MAX_PAGES)) &&
      rsp_total_bytes == '0)
      else $error("allocated run out of region");

   // Statistics stay ordered: longest run within free, free within total.
   a_stats_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_largest_free_bytes <= rsp_avail_bytes &&
      rsp_avail_bytes <= rsp_total_bytes)
      else $error("statistics out of order");

endmodule

bind next_fit_page_run_allocator_core nfpa_checker u_nfpa_checker (
   .clock                  (clock),
   .reset                  (reset),
   .rsp_valid              (rsp.valid),
   .rsp_ready              (rsp.ready),
   .rsp_status             (rsp.status),
   .rsp_run_first          (rsp.run_first),
   .rsp_run_len            (rsp.run_len),
   .rsp_total_bytes        (rsp.total_bytes),
   .rsp_avail_bytes        (rsp.avail_bytes),
   .rsp_largest_free_bytes (rsp.largest_free_bytes)
);
